@@ src/scu_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scu_pkg
// shared types and constants for the receiver frame unpack and scale block
// ----------------------------------------------------------------------------
package scu_pkg;

  localparam int NUM_CHANNELS = 16;

  localparam logic [4:0] IDLE_POS      = 5'd25;
  localparam logic [4:0] LAST_DATA_POS = 5'd22;

  localparam int CH_W   = 11;
  localparam int BUF_W  = 18;
  localparam int CNT_W  = 5;
  localparam int CHAN_W = 5;

  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  localparam logic [3:0][7:0] HDR_BYTES = {8'h81, 8'h15, 8'hEF, 8'hFE};
  localparam logic [7:0] HDR_SUM =
    8'((32'h0FE + 32'h0EF + 32'h015 + 32'h081) & 32'h0FF);

  localparam logic OP_HDR  = 1'b1;
  localparam logic OP_CHAN = 1'b0;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_start;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_last;
  } out_item_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] value;
    logic       has_sum;
    logic [7:0] sum;
  } op_t;

  typedef struct packed {
    logic push;
    op_t  op;
  } push_t;

endpackage

@@ src/scu_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scu_front
// accepts frame bytes, unpacks 11-bit channels, scales them and queues ops
// ----------------------------------------------------------------------------
module scu_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  scu_pkg::in_item_t in_data,
  input  logic             q_full,
  output scu_pkg::push_t   wr
);

  localparam logic [10:0] SCALE_OFS   = 11'd400;
  localparam logic [11:0] RECIP_12    = 12'd2731;
  localparam int          RECIP_SHIFT = 15;
  localparam logic [7:0]  SCALE_MAX   = 8'd100;

  logic [4:0]                 pos, pos_next;
  logic [scu_pkg::BUF_W-1:0]  bit_buf, bit_buf_next;
  logic [scu_pkg::CNT_W-1:0]  bit_cnt, bit_cnt_next;
  logic [scu_pkg::CHAN_W-1:0] chan, chan_next;
  logic [7:0]                 sum, sum_next;

  logic                       accept;
  logic [scu_pkg::BUF_W-1:0]  merged;
  logic [scu_pkg::CNT_W-1:0]  cnt_plus;
  logic [7:0]                 scaled;
  logic [7:0]                 sum_add;

  function automatic logic [7:0] scale(input logic [10:0] v);
    logic [10:0] d;
    logic [22:0] prod;
    logic [7:0]  q;
    d    = v - SCALE_OFS;
    prod = 23'(d) * 23'(RECIP_12);
    q    = prod[RECIP_SHIFT +: 8];
    if (v <= SCALE_OFS) begin
      scale = 8'd0;
    end else if (q > SCALE_MAX) begin
      scale = SCALE_MAX;
    end else begin
      scale = q;
    end
  endfunction

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign merged   = bit_buf | (scu_pkg::BUF_W'(in_data.frame_byte) << bit_cnt);
  assign cnt_plus = bit_cnt + scu_pkg::CNT_W'(8);
  assign scaled   = scale(merged[scu_pkg::CH_W-1:0]);
  assign sum_add  = sum + scaled;

  always_comb begin
    pos_next     = pos;
    bit_buf_next = bit_buf;
    bit_cnt_next = bit_cnt;
    chan_next    = chan;
    sum_next     = sum;
    wr.push       = 1'b0;
    wr.op.kind    = scu_pkg::OP_CHAN;
    wr.op.value   = scaled;
    wr.op.has_sum = 1'b0;
    wr.op.sum     = sum_add;
    if (accept) begin
      if (in_data.frame_start) begin
        pos_next     = 5'd1;
        bit_buf_next = '0;
        bit_cnt_next = '0;
        chan_next    = '0;
        sum_next     = scu_pkg::HDR_SUM;
        wr.push      = 1'b1;
        wr.op.kind   = scu_pkg::OP_HDR;
      end else if (pos < scu_pkg::IDLE_POS) begin
        pos_next = pos + 5'd1;
        if (pos <= scu_pkg::LAST_DATA_POS &&
            chan < scu_pkg::CHAN_W'(scu_pkg::NUM_CHANNELS)) begin
          if (cnt_plus >= scu_pkg::CNT_W'(scu_pkg::CH_W)) begin
            bit_buf_next  = merged >> scu_pkg::CH_W;
            bit_cnt_next  = cnt_plus - scu_pkg::CNT_W'(scu_pkg::CH_W);
            chan_next     = chan + scu_pkg::CHAN_W'(1);
            sum_next      = sum_add;
            wr.push       = 1'b1;
            wr.op.has_sum = (chan == scu_pkg::CHAN_W'(scu_pkg::NUM_CHANNELS - 1));
          end else begin
            bit_buf_next = merged;
            bit_cnt_next = cnt_plus;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= scu_pkg::IDLE_POS;
      bit_buf <= '0;
      bit_cnt <= '0;
      chan    <= '0;
      sum     <= '0;
    end else begin
      pos     <= pos_next;
      bit_buf <= bit_buf_next;
      bit_cnt <= bit_cnt_next;
      chan    <= chan_next;
      sum     <= sum_next;
    end
  end

endmodule

@@ src/scu_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scu_queue
// short op queue between the front and back parts
// ----------------------------------------------------------------------------
module scu_queue (
  input  logic           clk,
  input  logic           rst,
  input  scu_pkg::push_t wr,
  input  logic           pop,
  output scu_pkg::op_t   head,
  output logic           empty,
  output logic           full,
  output logic [scu_pkg::QAW:0] count
);

  scu_pkg::op_t            slots [scu_pkg::QDEPTH];
  logic [scu_pkg::QAW-1:0] wr_ptr, rd_ptr;
  logic                    do_push, do_pop;

  assign empty   = (count == '0);
  assign full    = (count == (scu_pkg::QAW+1)'(scu_pkg::QDEPTH));
  assign do_push = wr.push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr.op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + scu_pkg::QAW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + scu_pkg::QAW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + (scu_pkg::QAW+1)'(1);
      end else if (do_pop && !do_push) begin
        count <= count - (scu_pkg::QAW+1)'(1);
      end
    end
  end

endmodule

@@ src/scu_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scu_back
// expands queued ops into output bytes through an output register
// ----------------------------------------------------------------------------
module scu_back (
  input  logic              clk,
  input  logic              rst,
  input  scu_pkg::op_t      head,
  input  logic              empty,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output scu_pkg::out_item_t out_data
);

  logic [1:0] step, step_next;
  logic       load;
  logic       last_step;
  scu_pkg::out_item_t item;

  assign load = !empty && (!out_valid || out_ready);

  always_comb begin
    item.frame_last = 1'b0;
    if (head.kind == scu_pkg::OP_HDR) begin
      item.out_byte = scu_pkg::HDR_BYTES[step];
      last_step     = (step == 2'd3);
    end else if (step == 2'd0) begin
      item.out_byte = head.value;
      last_step     = !head.has_sum;
    end else begin
      item.out_byte   = head.sum;
      item.frame_last = 1'b1;
      last_step       = 1'b1;
    end
    pop       = load && last_step;
    step_next = step;
    if (load) begin
      step_next = last_step ? 2'd0 : step + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      step <= step_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ src/sbus_channel_unpack_scale_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbus_channel_unpack_scale_core
// unpacks a 25-byte receiver frame into 16 scaled channels, re-framed with
// header and checksum
// ----------------------------------------------------------------------------
//  port       | dir | item
//  in_*       | in  | frame_byte, frame_start (one raw frame byte)
//  out_*      | out | out_byte, frame_last (header, channel or checksum byte)
//
//  one input item per cycle while the four-entry op queue has room
//  output runs at one item per cycle from a registered stage while out_ready
//  is high; a start item expands to four header bytes, so the output port
//  sets the sustained rate; an op is stored in a queue slot, then registered
//  rst clears the frame position to idle and empties the queue
//  the two sides stall on their own: the queue absorbs output back-pressure
// ----------------------------------------------------------------------------
module sbus_channel_unpack_scale_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  scu_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output scu_pkg::out_item_t out_data
);

  scu_pkg::push_t            q_wr;
  scu_pkg::op_t              q_head;
  logic                      q_empty, q_full, q_pop;
  logic [scu_pkg::QAW:0]     q_count;

  scu_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .wr       (q_wr)
  );

  scu_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (q_wr),
    .pop   (q_pop),
    .head  (q_head),
    .empty (q_empty),
    .full  (q_full),
    .count (q_count)
  );

  scu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (q_head),
    .empty     (q_empty),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_start_queued: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_data.frame_start) |=> (q_count != '0))
    else $error("start item not queued");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_count <= (scu_pkg::QAW+1)'(scu_pkg::QDEPTH))
    else $error("op queue overflow");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    q_empty |-> !q_pop)
    else $error("pop from empty op queue");

endmodule
